// ----- hw/rtl/blob_slot_table_with_compaction_unit_assert.svh -----
// Assertion macros for the blob slot table unit.
`ifndef BLOB_SLOT_TABLE_WITH_COMPACTION_UNIT_ASSERT_SVH
`define BLOB_SLOT_TABLE_WITH_COMPACTION_UNIT_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define BST_ASSERT_IMPLY(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define BST_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/bst_pkg.sv -----
// Shared types and constants for the blob slot table unit.
package bst_pkg;

  localparam int SLOTS      = 32;
  localparam int DATA_BYTES = 1048576;
  localparam int SW         = 5;
  localparam int CW         = 6;
  localparam int AW         = 21;

  localparam logic [1:0] CMD_PUT = 2'd0;
  localparam logic [1:0] CMD_GET = 2'd1;
  localparam logic [1:0] CMD_UPD = 2'd2;
  localparam logic [1:0] CMD_DEL = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_LIVE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  localparam logic REG_CAP  = 1'b0;
  localparam logic REG_LIVE = 1'b1;

  typedef struct packed {
    logic [1:0]    cmd;
    logic [SW-1:0] slot;
    logic [AW-1:0] length;
  } req_t;

  typedef struct packed {
    logic          kind;
    logic [1:0]    status;
    logic [SW-1:0] slot_out;
    logic [AW-1:0] address;
    logic [AW-1:0] source;
    logic [AW-1:0] size_out;
    logic          last;
  } res_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture request, look up slot
    logic scan_start; // reset scan pointer
    logic scan_step;  // advance scan pointer
    logic do_put;
    logic do_upd;
    logic do_del;
    logic cmp_start;
    logic cmp_read;   // issue read of scan entry
    logic cmp_apply;  // process read data
    logic cmp_end;
    logic cmp_empty;
    logic out_reply;
    logic out_move;
    logic out_fail;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [1:0] cmd;
    logic       valid;
    logic       scan_hit;  // dead entry at scan pointer
    logic       scan_done;
    logic       put_fail;
    logic       upd_full;
    logic       need_cmp;
    logic       no_live;
    logic       move;
  } sts_t;

endpackage

// ----- hw/rtl/bst_ram.sv -----
// Generic single-port write, one-port registered read RAM.
module bst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/bst_ctrl.sv -----
// Command sequencer for the blob slot table unit.
module bst_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           out_full,
  input  bst_pkg::sts_t  sts,
  output bst_pkg::cmd_t  cmd,
  output logic           busy
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOOK  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_SCANW = 4'd3;
  localparam logic [3:0] S_EXEC  = 4'd4;
  localparam logic [3:0] S_CRD   = 4'd5;
  localparam logic [3:0] S_CWAIT = 4'd6;
  localparam logic [3:0] S_CAPP  = 4'd7;
  localparam logic [3:0] S_REPLY = 4'd8;
  localparam logic [3:0] S_REPW  = 4'd9;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);
  assign busy     = (state != S_IDLE);

  // Sequence one request at a time.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        // slot entry read data is now available
        if (sts.cmd == bst_pkg::CMD_PUT) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCANW;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_SCANW: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_hit || sts.scan_done) begin
          state_next = S_EXEC;
        end else begin
          cmd.scan_step = 1'b1;
          state_next    = S_SCANW;
        end
      end
      S_EXEC: begin
        if (!out_full) begin
          if (sts.cmd == bst_pkg::CMD_PUT) begin
            if (sts.put_fail) begin
              cmd.out_fail = 1'b1;
            end else begin
              cmd.do_put    = 1'b1;
              cmd.out_reply = 1'b1;
            end
            state_next = S_IDLE;
          end else if (!sts.valid) begin
            cmd.out_fail = 1'b1;
            state_next   = S_IDLE;
          end else if (sts.cmd == bst_pkg::CMD_GET) begin
            cmd.out_reply = 1'b1;
            state_next    = S_IDLE;
          end else if (sts.cmd == bst_pkg::CMD_UPD && sts.upd_full) begin
            cmd.out_fail = 1'b1;
            state_next   = S_IDLE;
          end else begin
            cmd.do_upd = (sts.cmd == bst_pkg::CMD_UPD);
            cmd.do_del = (sts.cmd == bst_pkg::CMD_DEL);
            state_next = S_REPLY;
          end
        end
      end
      S_REPLY: begin
        // counters updated; decide on compaction
        if (sts.need_cmp) begin
          if (sts.no_live) begin
            cmd.cmp_empty = 1'b1;
            state_next    = S_REPW;
          end else begin
            cmd.cmp_start = 1'b1;
            state_next    = S_CRD;
          end
        end else begin
          state_next = S_REPW;
        end
      end
      S_CRD: begin
        if (sts.scan_done) begin
          cmd.cmp_end = 1'b1;
          state_next  = S_REPW;
        end else begin
          cmd.cmp_read = 1'b1;
          state_next   = S_CWAIT;
        end
      end
      S_CWAIT: begin
        state_next = S_CAPP;
      end
      S_CAPP: begin
        if (!(sts.move && out_full)) begin
          cmd.cmp_apply = 1'b1;
          cmd.out_move  = sts.move;
          state_next    = S_CRD;
        end
      end
      S_REPW: begin
        if (!out_full) begin
          cmd.out_reply = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ----- hw/rtl/bst_dp.sv -----
// Slot table, counters and result formation for the blob slot table unit.
module bst_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  bst_pkg::req_t        req,
  input  bst_pkg::cmd_t        cmd,
  output bst_pkg::sts_t        sts,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [20:0]          cfg_data,
  output logic                 res_we,
  output bst_pkg::res_t        res
);
  localparam int EW = 2 * bst_pkg::AW + 1;

  logic [bst_pkg::AW-1:0] data_capacity;
  logic [bst_pkg::CW-1:0] max_live;
  logic [bst_pkg::CW-1:0] slots_in_use, live_blobs;
  logic [bst_pkg::AW-1:0] bytes_used, bytes_dead;
  bst_pkg::req_t          r;

  // entry of request slot, captured after lookup
  logic [bst_pkg::AW-1:0] e_addr, e_len;
  logic                   e_dead;
  logic [bst_pkg::SW-1:0] track;     // slot followed through compaction
  logic                   track_ok;
  logic [bst_pkg::AW-1:0] rep_addr, rep_len;

  // scan and compaction pointers
  logic [bst_pkg::CW-1:0] ptr;
  logic [bst_pkg::CW-1:0] wptr;
  logic [bst_pkg::AW-1:0] used_acc;
  logic                   lookup_phase;

  // memory ports
  logic                   m_we;
  logic [bst_pkg::SW-1:0] m_waddr, m_raddr;
  logic [EW-1:0]          m_wdata, m_rdata;
  logic [bst_pkg::AW-1:0] rd_addr, rd_len;
  logic                   rd_dead;

  bst_ram #(.WIDTH(EW), .DEPTH(bst_pkg::SLOTS)) u_tab (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  assign {rd_addr, rd_len, rd_dead} = m_rdata;
  assign m_raddr = cmd.load ? req.slot : ptr[bst_pkg::SW-1:0];

  // Limits and derived tests.
  logic [bst_pkg::AW-1:0] cap;
  logic [bst_pkg::AW:0]   sum_len;
  logic [bst_pkg::AW-1:0] dead_new, used_new;
  logic [bst_pkg::AW+2:0] used_x5;
  logic                   fits;

  assign cap     = (data_capacity > bst_pkg::AW'(bst_pkg::DATA_BYTES))
                   ? bst_pkg::AW'(bst_pkg::DATA_BYTES) : data_capacity;
  assign sum_len = {1'b0, bytes_used} + {1'b0, r.length};
  assign fits    = (sum_len <= {1'b0, cap});
  // dead > floor(used/5) holds exactly when 5*dead > used
  assign used_x5 = {1'b0, bytes_dead, 2'b00} + {3'b000, bytes_dead};

  always_comb begin
    sts           = '0;
    sts.cmd       = r.cmd;
    sts.valid     = ({1'b0, r.slot} < slots_in_use) && !e_dead;
    sts.scan_hit  = !lookup_phase && rd_dead && (ptr < slots_in_use);
    sts.scan_done = (ptr >= slots_in_use);
    sts.put_fail  = (live_blobs >= max_live)
                    || (!sts.scan_hit && slots_in_use >= bst_pkg::CW'(bst_pkg::SLOTS))
                    || !fits;
    sts.upd_full  = !fits;
    sts.need_cmp  = (used_x5 > {3'b000, bytes_used});
    sts.no_live   = (live_blobs == '0);
    sts.move      = !rd_dead && ((wptr != ptr) || (rd_addr != used_acc));
  end

  // Table writes.
  always_comb begin
    m_we    = 1'b0;
    m_waddr = r.slot;
    m_wdata = '0;
    if (cmd.do_put) begin
      m_we    = 1'b1;
      m_waddr = ptr[bst_pkg::SW-1:0];
      m_wdata = {bytes_used, r.length, 1'b0};
    end else if (cmd.do_upd) begin
      m_we    = 1'b1;
      m_wdata = {bytes_used, r.length, 1'b0};
    end else if (cmd.do_del) begin
      m_we    = 1'b1;
      m_wdata = {e_addr, e_len, 1'b1};
    end else if (cmd.cmp_apply && !rd_dead) begin
      m_we    = 1'b1;
      m_waddr = wptr[bst_pkg::SW-1:0];
      m_wdata = {used_acc, rd_len, 1'b0};
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      data_capacity <= bst_pkg::AW'(1048576);
      max_live      <= bst_pkg::CW'(32);
    end else if (cfg_we) begin
      if (cfg_index == bst_pkg::REG_CAP) begin
        data_capacity <= cfg_data;
      end else begin
        max_live <= cfg_data[bst_pkg::CW-1:0];
      end
    end
  end

  // Counters and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= '0;
      live_blobs   <= '0;
      bytes_used   <= '0;
      bytes_dead   <= '0;
      lookup_phase <= 1'b0;
      ptr          <= '0;
    end else begin
      lookup_phase <= cmd.load;
      if (cmd.load) begin
        r <= req;
      end
      if (lookup_phase) begin
        e_addr <= rd_addr;
        e_len  <= rd_len;
        e_dead <= rd_dead;
      end
      if (cmd.scan_start) begin
        ptr <= '0;
      end
      if (cmd.scan_step) begin
        ptr <= ptr + 1'b1;
      end
      if (cmd.do_put) begin
        if (ptr >= slots_in_use) begin
          slots_in_use <= slots_in_use + 1'b1;
        end
        live_blobs <= live_blobs + 1'b1;
        bytes_used <= bytes_used + r.length;
        rep_addr   <= bytes_used;
        rep_len    <= r.length;
        track      <= ptr[bst_pkg::SW-1:0];
      end
      if (cmd.do_upd) begin
        bytes_dead <= bytes_dead + e_len;
        bytes_used <= bytes_used + r.length;
        rep_addr   <= bytes_used;
        rep_len    <= r.length;
        track      <= r.slot;
        track_ok   <= 1'b1;
      end
      if (cmd.do_del) begin
        live_blobs <= live_blobs - 1'b1;
        bytes_dead <= bytes_dead + e_len;
        rep_addr   <= '0;
        rep_len    <= e_len;
        track      <= r.slot;
        track_ok   <= 1'b0;
      end
      if (cmd.cmp_empty) begin
        slots_in_use <= '0;
        bytes_used   <= '0;
        bytes_dead   <= '0;
      end
      if (cmd.cmp_start) begin
        ptr      <= '0;
        wptr     <= '0;
        used_acc <= '0;
      end
      if (cmd.cmp_apply) begin
        ptr <= ptr + 1'b1;
        if (!rd_dead) begin
          if (track_ok && ptr[bst_pkg::SW-1:0] == r.slot) begin
            track    <= wptr[bst_pkg::SW-1:0];
            rep_addr <= used_acc;
          end
          used_acc <= used_acc + rd_len;
          wptr     <= wptr + 1'b1;
        end
      end
      if (cmd.cmp_end) begin
        slots_in_use <= wptr;
        bytes_used   <= used_acc;
        bytes_dead   <= '0;
      end
    end
  end

  // Result formation.
  always_comb begin
    res_we = cmd.out_reply || cmd.out_move || cmd.out_fail;
    res    = '0;
    if (cmd.out_move) begin
      res.kind     = 1'b1;
      res.slot_out = wptr[bst_pkg::SW-1:0];
      res.address  = used_acc;
      res.source   = rd_addr;
      res.size_out = rd_len;
    end else if (cmd.out_fail) begin
      res.last = 1'b1;
      res.slot_out = (r.cmd == bst_pkg::CMD_PUT) ? '0 : r.slot;
      if (r.cmd == bst_pkg::CMD_PUT) begin
        res.status = ((live_blobs >= max_live)
                      || (!sts.scan_hit && slots_in_use >= bst_pkg::CW'(bst_pkg::SLOTS)))
                     ? bst_pkg::ST_LIVE : bst_pkg::ST_FULL;
      end else if (!sts.valid) begin
        res.status = bst_pkg::ST_BAD;
      end else begin
        res.status = bst_pkg::ST_FULL;
      end
    end else if (cmd.out_reply) begin
      res.last = 1'b1;
      if (r.cmd == bst_pkg::CMD_GET) begin
        res.slot_out = r.slot;
        res.address  = e_addr;
        res.size_out = e_len;
      end else if (r.cmd == bst_pkg::CMD_PUT) begin
        res.slot_out = ptr[bst_pkg::SW-1:0];
        res.address  = bytes_used;
        res.size_out = r.length;
      end else begin
        res.slot_out = track;
        res.address  = rep_addr;
        res.size_out = rep_len;
      end
    end
  end
endmodule

// ----- hw/rtl/blob_slot_table_with_compaction_unit.sv -----
// Blob slot table unit: top level with output register.
// One request at a time; the unit takes no new request until the last one
// is done. Get, and any failed update or delete, goes through lookup and
// execute only. Put also scans the table for a dead slot to reuse. An update
// or delete may then compact the table, walking every entry in use, as
// each entry needs a read of the slot table RAM before it can be packed.
// Every result, move order or reply, waits in place while the output is
// stalled. A move order is emitted for each relocated blob, then the
// command reply.
module blob_slot_table_with_compaction_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  bst_pkg::req_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output bst_pkg::res_t  out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [20:0]    cfg_data
);
  bst_pkg::cmd_t cmd;
  bst_pkg::sts_t sts;
  bst_pkg::res_t res;
  logic          res_we, busy, out_full;

  assign cfg_ready = 1'b1;
  // Output register can take a new result when empty or being drained.
  assign out_full  = out_valid && out_stall;

  bst_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_full(out_full), .sts(sts), .cmd(cmd), .busy(busy)
  );

  bst_dp u_dp (
    .clk(clk), .rst(rst), .req(in_data), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .res_we(res_we), .res(res)
  );

  // Hold the result until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_we) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_we) begin
      out_data <= res;
    end
  end

`include "blob_slot_table_with_compaction_unit_assert.svh"
  `BST_ASSERT_IMPLY(a_no_write_full, clk, rst, res_we, !out_full)
  `BST_ASSERT_NEXT(a_last_idle, clk, rst, res_we && res.last, !busy)
  `BST_ASSERT_IMPLY(a_move_not_last, clk, rst, out_valid && out_data.kind, !out_data.last)
endmodule
